### design/hte_pkg.sv
`default_nettype none
package hte_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_HOTP   = 2'd1;
    localparam logic [1:0] OP_TOTP   = 2'd2;
    localparam logic [1:0] OP_VERIFY = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_DIGITS     = 3'd1;
    localparam logic [2:0] CFG_STEP       = 3'd2;
    localparam logic [2:0] CFG_EPOCH      = 3'd3;
    localparam logic [2:0] CFG_DRIFT      = 3'd4;

    localparam int KEY_WORDS   = 16;
    localparam int STORE_BYTES = KEY_WORDS * 8;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;

    // handshake status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic [29:0] pow10(input logic [3:0] d);
        logic [29:0] r;
        case (d)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            default: r = 30'd1000000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### design/hotp_totp_engine.sv
// HOTP / TOTP one-time password engine on HMAC-SHA-1.
// Input stream (s_*): tuser carries the op, tdata the key index, key word,
// value and submitted code. A key-write beat lands in the key store in the
// cycle it is taken and gives no result. HOTP, TOTP and verify beats each
// give one result beat on m_*: code in tdata[29:0], match in tdata[30].
// Config channel (i_cfg_*) is always ready; write only while idle.
// Steps: key fetch from the key store, a SHA-1 hash of the key if it is
// longer than 64 bytes, the step divide for TOTP and verify, then per HMAC
// four SHA-1 blocks on the shared round unit, then the mod 10^digits on the
// shared divider.
// Verify repeats the HMAC for each tried step, up to 2*drift+1 of them.
// One item is in flight at a time; s_tready is high only when idle, so a
// new beat is taken while a finished result still sits in the output
// register. If m_tready is low the engine holds in its final state until
// the output register is free.
// Reset (synchronous, active low) sets the config registers to their
// defaults and clears control; the key store is not cleared.
`default_nettype none
module hotp_totp_engine #(
    parameter int KEY_MAX_BYTES = 128,
    parameter int DIGITS_MIN    = 6,
    parameter int STEP_DEFAULT  = 30
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: key_index[3:0], key_word[67:4], value[131:68], otp[163:132]
    input  wire logic [167:0] s_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: code[29:0], match[30]
    output logic      [31:0]  m_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    import hte_pkg::*;

    localparam int KEY_LIM = (KEY_MAX_BYTES < STORE_BYTES) ? KEY_MAX_BYTES : STORE_BYTES;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KRD    = 4'd1;
    localparam logic [3:0] S_KPAD   = 4'd2;
    localparam logic [3:0] S_PREP   = 4'd3;
    localparam logic [3:0] S_TDIV   = 4'd4;
    localparam logic [3:0] S_TGOT   = 4'd5;
    localparam logic [3:0] S_VNEXT  = 4'd6;
    localparam logic [3:0] S_CTR    = 4'd7;
    localparam logic [3:0] S_HSTART = 4'd8;
    localparam logic [3:0] S_HWAIT  = 4'd9;
    localparam logic [3:0] S_HEND   = 4'd10;
    localparam logic [3:0] S_MOD    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    localparam logic [1:0] PH_KEY   = 2'd0;
    localparam logic [1:0] PH_INNER = 2'd1;
    localparam logic [1:0] PH_OUTER = 2'd2;

    // config
    logic [7:0]  r_key_length;
    logic [3:0]  r_digits;
    logic [31:0] r_step;
    logic [63:0] r_epoch;
    logic [7:0]  r_drift;

    // item and sequencer
    logic [3:0]   r_state;
    logic [1:0]   r_op;
    logic [63:0]  r_value;
    logic [31:0]  r_otp;
    logic [4:0]   r_kcnt;
    logic [1023:0] r_mbuf;
    logic [7:0]   r_len;
    logic [1:0]   r_blk;
    logic [159:0] r_h;
    logic [1:0]   r_phase;
    logic [511:0] r_pad;
    logic [63:0]  r_ctr;
    logic [63:0]  r_t;
    logic [7:0]   r_k;
    logic [31:0]  r_res;
    logic         r_out_valid;
    logic [31:0]  r_out_data;

    logic         in_acc;
    logic [63:0]  mem_rdata;
    logic [159:0] sha_h;
    t_unit_sts    sha_sts, div_sts;
    logic         sha_start, div_start;
    logic [63:0]  div_a, div_q;
    logic [31:0]  div_b, div_r;
    logic [511:0] blk_data, pad_masked;
    logic [1:0]   nblk;
    logic [7:0]   key_n;
    logic [29:0]  modulus;
    logic [31:0]  step_x;
    logic [159:0] h_sh;
    logic [30:0]  sbits;
    logic [7:0]   d_w, d2_w;
    logic [64:0]  v_back, v_fwd;
    logic         out_free;

    assign in_acc      = s_tvalid && s_tready;
    assign s_tready    = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || m_tready;

    assign key_n   = (r_key_length > 8'(KEY_LIM)) ? 8'(KEY_LIM) : r_key_length;
    assign step_x  = (r_step == 32'd0) ? 32'(STEP_DEFAULT) : r_step;
    assign modulus = pow10((r_digits == 4'd0) ? 4'(DIGITS_MIN) :
                           ((r_digits > 4'd9) ? 4'd9 : r_digits));
    assign nblk    = 2'(((9'(r_len) + 9'd8) >> 6) + 9'd1);

    // dynamic truncation of the final digest
    assign h_sh  = r_h << {r_h[3:0], 3'b000};
    assign sbits = h_sh[158:128];

    assign d_w    = {1'b0, r_drift[6:0]};
    assign d2_w   = {r_drift[6:0], 1'b0};
    assign v_back = {1'b0, r_t} - 65'(d_w - r_k);
    assign v_fwd  = {1'b0, r_t} + 65'(r_k - d_w);

    // padded SHA-1 block r_blk of the message in r_mbuf
    always_comb begin
        logic [7:0]  p, totb, by;
        logic [10:0] nbits;
        logic [2:0]  j;
        totb  = {nblk, 6'd0};
        nbits = {r_len, 3'b000};
        for (int i = 0; i < 64; i++) begin
            p = {r_blk, 6'(i)};
            j = 3'(totb - 8'd1 - p);
            if (p < r_len) begin
                by = r_mbuf[1023 - 8*p[6:0] -: 8];
            end else if (p == r_len) begin
                by = 8'h80;
            end else if (p >= totb - 8'd8) begin
                by = 8'(64'(nbits) >> {j, 3'b000});
            end else begin
                by = 8'h00;
            end
            blk_data[511 - 8*i -: 8] = by;
        end
    end

    // short key: bytes beyond the key length read as zero
    always_comb begin
        for (int i = 0; i < 64; i++) begin
            pad_masked[511 - 8*i -: 8] = (8'(i) < key_n) ? r_mbuf[1023 - 8*i -: 8] : 8'h00;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_a     = r_value - r_epoch;
        div_b     = step_x;
        if (r_state == S_PREP && r_op != OP_HOTP && !(r_op == OP_VERIFY && r_drift[7])
            && r_value >= r_epoch) begin
            div_start = 1'b1;
        end
        if (r_state == S_HEND && r_phase == PH_OUTER) begin
            div_start = 1'b1;
            div_a     = 64'(sbits);
            div_b     = 32'(modulus);
        end
    end

    assign sha_start = (r_state == S_HSTART);

    hte_keymem u_keymem (
        .i_clk   (i_clk),
        .i_we    (in_acc && s_tuser == OP_KEY),
        .i_waddr (s_tdata[3:0]),
        .i_wdata (s_tdata[67:4]),
        .i_raddr (r_kcnt[3:0]),
        .o_rdata (mem_rdata)
    );

    hte_sha1 u_sha1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sha_start),
        .i_block (blk_data),
        .i_h     (r_h),
        .o_h     (sha_h),
        .o_sts   (sha_sts)
    );

    hte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_quot     (div_q),
        .o_rem      (div_r),
        .o_sts      (div_sts)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 8'd0;
            r_digits     <= 4'd6;
            r_step       <= 32'd30;
            r_epoch      <= 64'd0;
            r_drift      <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[7:0];
                CFG_DIGITS:     r_digits     <= i_cfg_data[3:0];
                CFG_STEP:       r_step       <= i_cfg_data[31:0];
                CFG_EPOCH:      r_epoch      <= i_cfg_data;
                CFG_DRIFT:      r_drift      <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && s_tuser != OP_KEY) begin
                        r_state <= S_KRD;
                    end
                end
                S_KRD: begin
                    if (r_kcnt == 5'd16) begin
                        r_state <= S_KPAD;
                    end
                end
                S_KPAD: begin
                    r_state <= (key_n > 8'd64) ? S_HSTART : S_PREP;
                end
                S_PREP: begin
                    if (r_op == OP_HOTP) begin
                        r_state <= S_CTR;
                    end else if (r_op == OP_VERIFY && r_drift[7]) begin
                        r_state <= S_DONE;
                    end else if (r_value < r_epoch) begin
                        r_state <= S_TGOT;
                    end else begin
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_sts.done) begin
                        r_state <= S_TGOT;
                    end
                end
                S_TGOT: begin
                    r_state <= (r_op == OP_TOTP) ? S_CTR : S_VNEXT;
                end
                S_VNEXT: begin
                    if (r_k > d2_w) begin
                        r_state <= S_DONE;
                    end else if (r_k < d_w) begin
                        if (!v_back[64]) begin
                            r_state <= S_CTR;
                        end
                    end else if (!v_fwd[64]) begin
                        r_state <= S_CTR;
                    end
                end
                S_CTR:    r_state <= S_HSTART;
                S_HSTART: r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (sha_sts.done) begin
                        r_state <= (r_blk == nblk - 2'd1) ? S_HEND : S_HSTART;
                    end
                end
                S_HEND: begin
                    case (r_phase)
                        PH_KEY:   r_state <= S_PREP;
                        PH_INNER: r_state <= S_HSTART;
                        default:  r_state <= S_MOD;
                    endcase
                end
                S_MOD: begin
                    if (div_sts.done) begin
                        if (r_op != OP_VERIFY || {2'b00, div_r[29:0]} == r_otp) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_VNEXT;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= s_tuser;
                r_value <= s_tdata[131:68];
                r_otp   <= s_tdata[163:132];
                r_kcnt  <= 5'd0;
                r_res   <= 32'd0;
            end
            S_KRD: begin
                // store read data is registered, so it arrives in the cycle after its address
                if (r_kcnt != 5'd0) begin
                    r_mbuf[1023 - 64*(4'(r_kcnt - 5'd1)) -: 64] <= mem_rdata;
                end
                r_kcnt <= r_kcnt + 5'd1;
            end
            S_KPAD: begin
                r_pad   <= pad_masked;
                r_len   <= key_n;
                r_phase <= PH_KEY;
                r_blk   <= 2'd0;
                r_h     <= SHA1_IV;
            end
            S_PREP: begin
                r_ctr <= r_value;
                r_t   <= 64'd0;
            end
            S_TDIV: begin
                if (div_sts.done) begin
                    r_t <= div_q;
                end
            end
            S_TGOT: begin
                r_ctr <= r_t;
                r_k   <= 8'd0;
            end
            S_VNEXT: begin
                r_k   <= r_k + 8'd1;
                r_ctr <= (r_k < d_w) ? v_back[63:0] : v_fwd[63:0];
            end
            S_CTR: begin
                r_mbuf  <= {r_pad ^ {64{IPAD}}, r_ctr, 448'd0};
                r_len   <= 8'd72;
                r_phase <= PH_INNER;
                r_blk   <= 2'd0;
                r_h     <= SHA1_IV;
            end
            S_HWAIT: begin
                if (sha_sts.done) begin
                    r_h   <= sha_h;
                    r_blk <= r_blk + 2'd1;
                end
            end
            S_HEND: begin
                if (r_phase == PH_KEY) begin
                    r_pad <= {r_h, 352'd0};
                end else if (r_phase == PH_INNER) begin
                    r_mbuf  <= {r_pad ^ {64{OPAD}}, r_h, 352'd0};
                    r_len   <= 8'd84;
                    r_phase <= PH_OUTER;
                    r_blk   <= 2'd0;
                    r_h     <= SHA1_IV;
                end
            end
            S_MOD: begin
                if (div_sts.done) begin
                    if (r_op != OP_VERIFY) begin
                        r_res <= {2'b00, div_r[29:0]};
                    end else if ({2'b00, div_r[29:0]} == r_otp) begin
                        r_res <= 32'h4000_0000;
                    end
                end
            end
            S_DONE: begin
                // result moves to the output register once that is free
                if (out_free) begin
                    r_out_data <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // a round unit finishing outside its wait state means a lost block
    a_sha_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sha_sts.done |-> (r_state == S_HWAIT))
        else $error("sha1 finished outside wait");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_TDIV || r_state == S_MOD))
        else $error("divider finished outside wait");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!sha_sts.busy && !div_sts.busy))
        else $error("unit busy while idle");

    a_blk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HSTART) |-> (r_blk < nblk))
        else $error("block index past message end");

endmodule
`default_nettype wire

### design/hte_keymem.sv
`default_nettype none
module hte_keymem (
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [3:0]  i_waddr,
    input  wire logic [63:0] i_wdata,
    input  wire logic [3:0]  i_raddr,
    output logic      [63:0] o_rdata
);
    logic [63:0] r_mem [16];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/hte_sha1.sv
`default_nettype none
module hte_sha1 (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [511:0]  i_block,
    input  wire logic [159:0]  i_h,
    output logic      [159:0]  o_h,
    output hte_pkg::t_unit_sts o_sts
);
    import hte_pkg::*;

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [6:0]  r_t;
    logic        r_busy, r_done;
    logic [159:0] r_h;
    logic [31:0] f, k, tmp, wnew;

    always_comb begin
        if (r_t < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = 32'h5A827999;
        end else if (r_t < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = 32'h6ED9EBA1;
        end else if (r_t < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = 32'h8F1BBCDC;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = 32'hCA62C1D6;
        end
        tmp  = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_w[0];
        wnew = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        wnew = {wnew[30:0], wnew[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_t    <= '0;
        end else begin
            r_done <= r_busy && (r_t == 7'd79);
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_t    <= '0;
            end else if (r_busy) begin
                r_t <= r_t + 7'd1;
                if (r_t == 7'd79) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            {r_a, r_b, r_c, r_d, r_e} <= i_h;
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
        end else if (r_busy) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= wnew;
            if (r_t == 7'd79) begin
                r_h <= {i_h[159:128] + tmp,
                        i_h[127:96]  + r_a,
                        i_h[95:64]   + {r_b[1:0], r_b[31:2]},
                        i_h[63:32]   + r_c,
                        i_h[31:0]    + r_d};
            end
        end
    end

    assign o_h        = r_h;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule
`default_nettype wire

### design/hte_div.sv
`default_nettype none
module hte_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [63:0]   i_dividend,
    input  wire logic [31:0]   i_divisor,
    output logic      [63:0]   o_quot,
    output logic      [31:0]   o_rem,
    output hte_pkg::t_unit_sts o_sts
);
    import hte_pkg::*;

    logic [63:0] r_q;
    logic [31:0] r_r, r_d;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] sh, diff;

    // restoring division, one quotient bit a cycle
    assign sh   = {r_r, r_q[63]};
    assign diff = sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_r <= diff[31:0];
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= sh[31:0];
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_quot     = r_q;
    assign o_rem      = r_r;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hte_pkg::*;

    // one password result as it leaves the engine
    typedef struct packed {
        logic [29:0] code;
        logic        match;
    } otp_result_t;

    // scoreboard: own copy of key store and registers, HMAC-SHA-1 predictor
    class otp_scoreboard;
        logic [63:0] key_store [16];
        logic [7:0]  key_length;
        logic [3:0]  digits;
        logic [31:0] step_seconds;
        logic [63:0] epoch_start;
        logic [7:0]  drift_window;
        otp_result_t awaited [$];
        int          errors;

        function new();
            foreach (key_store[i]) key_store[i] = '0;
            key_length   = 8'd0;
            digits       = 4'd6;
            step_seconds = 32'd30;
            epoch_start  = 64'd0;
            drift_window = 8'sd1;
            errors       = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [63:0] data);
            case (idx)
                CFG_KEY_LENGTH: key_length   = data[7:0];
                CFG_DIGITS:     digits       = data[3:0];
                CFG_STEP:       step_seconds = data[31:0];
                CFG_EPOCH:      epoch_start  = data;
                CFG_DRIFT:      drift_window = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] rotl(input logic [31:0] x, input int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function logic [159:0] sha1(input logic [7:0] msg [256], input int len);
            logic [31:0] h [5];
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            logic [63:0] bits;
            logic [7:0]  by;
            int          total, p;
            h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
            h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
            total = ((len + 8) / 64 + 1) * 64;
            bits  = 64'(len) * 8;
            for (int blk = 0; blk < total; blk += 64) begin
                for (int i = 0; i < 16; i++) begin
                    w[i] = '0;
                    for (int j = 0; j < 4; j++) begin
                        p = blk + i * 4 + j;
                        if (p < len) by = msg[p];
                        else if (p == len) by = 8'h80;
                        else if (p >= total - 8) by = 8'(bits >> (8 * (total - 1 - p)));
                        else by = 8'h00;
                        w[i] = {w[i][23:0], by};
                    end
                end
                for (int i = 16; i < 80; i++)
                    w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
                a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
                for (int i = 0; i < 80; i++) begin
                    if (i < 20) begin
                        f = (b & c) | (~b & d); k = 32'h5A827999;
                    end else if (i < 40) begin
                        f = b ^ c ^ d; k = 32'h6ED9EBA1;
                    end else if (i < 60) begin
                        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
                    end else begin
                        f = b ^ c ^ d; k = 32'hCA62C1D6;
                    end
                    t = rotl(a, 5) + f + e + k + w[i];
                    e = d; d = c; c = rotl(b, 30); b = a; a = t;
                end
                h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
            end
            return {h[0], h[1], h[2], h[3], h[4]};
        endfunction

        function logic [31:0] modulus();
            logic [31:0] m;
            int          nd;
            nd = (digits == 0) ? 6 : (digits > 9) ? 9 : int'(digits);
            m = 1;
            repeat (nd) m = m * 10;
            return m;
        endfunction

        function logic [63:0] step_of(input logic [63:0] now);
            logic [63:0] x;
            x = (step_seconds == 0) ? 64'd30 : 64'(step_seconds);
            if (now < epoch_start) return 64'd0;
            return (now - epoch_start) / x;
        endfunction

        function logic [31:0] hotp(input logic [63:0] counter, input logic [31:0] m);
            logic [7:0]   raw [256];
            logic [7:0]   pad [64];
            logic [7:0]   buff [256];
            logic [159:0] dig, inner, hs;
            logic [3:0]   off;
            logic [31:0]  sbits;
            int           n;
            n = (key_length > 128) ? 128 : int'(key_length);
            foreach (raw[i]) raw[i] = (i < 128) ? key_store[i/8][63-8*(i%8) -: 8] : 8'h00;
            foreach (pad[i]) pad[i] = 8'h00;
            if (n > 64) begin
                dig = sha1(raw, n);
                for (int i = 0; i < 20; i++) pad[i] = dig[159-8*i -: 8];
            end else begin
                for (int i = 0; i < n; i++) pad[i] = raw[i];
            end
            foreach (buff[i]) buff[i] = 8'h00;
            for (int i = 0; i < 64; i++) buff[i] = pad[i] ^ IPAD;
            for (int i = 0; i < 8; i++) buff[64+i] = counter[63-8*i -: 8];
            inner = sha1(buff, 72);
            for (int i = 0; i < 64; i++) buff[i] = pad[i] ^ OPAD;
            for (int i = 0; i < 20; i++) buff[64+i] = inner[159-8*i -: 8];
            hs = sha1(buff, 84);
            off = hs[3:0];
            sbits = hs[159-8*off -: 32];
            sbits[31] = 1'b0;
            return sbits % m;
        endfunction

        // accepted input beat: update store or queue the password it yields
        function void note_input(input logic [1:0] op, input logic [3:0] idx,
                                 input logic [63:0] word, input logic [63:0] value,
                                 input logic [31:0] otp);
            otp_result_t r;
            logic [63:0] ts, cand;
            int          d;
            r = '0;
            case (op)
                OP_KEY: begin
                    key_store[idx] = word;
                    return;
                end
                OP_HOTP: r.code = 30'(hotp(value, modulus()));
                OP_TOTP: r.code = 30'(hotp(step_of(value), modulus()));
                default: begin
                    if (!drift_window[7]) begin
                        ts = step_of(value);
                        d  = int'(drift_window[6:0]);
                        for (int j = -d; j <= d && !r.match; j++) begin
                            if (j < 0 && ts < 64'(-j)) continue;
                            if (j > 0 && ts > 64'hFFFF_FFFF_FFFF_FFFF - 64'(j)) continue;
                            cand = ts + 64'(signed'(j));
                            if (hotp(cand, modulus()) == otp) r.match = 1'b1;
                        end
                    end
                end
            endcase
            awaited.push_back(r);
        endfunction

        function void check(input logic [31:0] beat);
            otp_result_t e;
            if (awaited.size() == 0) begin
                $error("result beat %h with nothing awaited", beat);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (beat[29:0] !== e.code) begin
                $error("code: expected %0d, actual %0d", e.code, beat[29:0]);
                errors++;
            end
            if (beat[30] !== e.match) begin
                $error("match: expected %0d, actual %0d", e.match, beat[30]);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [167:0] s_tdata = '0;   // key_index, key_word, value, otp from bit 0 up
    logic [1:0]   s_tuser = OP_KEY; // op
    wire          m_tvalid;
    logic         m_tready = 1'b1;
    wire  [31:0]  m_tdata;        // code[29:0], match[30]
    logic         i_cfg_valid = 1'b0;
    wire          o_cfg_ready;
    logic [2:0]   i_cfg_index = CFG_KEY_LENGTH;
    logic [63:0]  i_cfg_data = '0;

    otp_scoreboard sb = new();
    bit calm = 1'b0;        // set for the closing stretch: no idling either side
    int sink_stall = 0;
    int quiet_cycles = 0;

    hotp_totp_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: check each beat taken, back-pressure in random bursts
    always @(posedge i_clk) begin
        if (m_tvalid && m_tready)
            sb.check(m_tdata);
        if (sink_stall > 0) begin
            sink_stall--;
            if (sink_stall == 0)
                m_tready <= 1'b1;
        end else if (!calm && i_rst_n && $urandom_range(0, 11) == 0) begin
            m_tready   <= 1'b0;
            sink_stall = $urandom_range(1, 18);
        end
    end

    // watchdog on cycles without any beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // one config beat; valid stays up so writes can run back to back
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // full register set, with junk in the bits above each register
    task automatic program_regs(input logic [7:0] kl, input logic [3:0] dg,
                                input logic [31:0] st, input logic [63:0] ep,
                                input logic [7:0] dr);
        logic [63:0] junk;
        junk = rnd64();
        write_reg(CFG_KEY_LENGTH, {junk[63:8], kl});
        write_reg(CFG_DIGITS,     {junk[63:4], dg});
        write_reg(CFG_STEP,       {junk[63:32], st});
        write_reg(CFG_EPOCH,      ep);
        write_reg(CFG_DRIFT,      {junk[63:8], dr});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(input logic [1:0] op, input logic [3:0] idx,
                             input logic [63:0] word, input logic [63:0] value,
                             input logic [31:0] otp);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, otp, value, word, idx};
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(op, idx, word, value, otp);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // hold the sender until every password is back and the engine is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // code of a step inside the drift window, so verify has a chance to match
    function automatic logic [31:0] window_code(input logic [63:0] value);
        logic [63:0] ts;
        int          d, j;
        ts = sb.step_of(value);
        d  = sb.drift_window[7] ? 1 : int'(sb.drift_window[6:0]);
        j  = $urandom_range(0, 2 * d) - d;
        return sb.hotp(ts + 64'(signed'(j)), sb.modulus());
    endfunction

    task automatic random_beat();
        logic [63:0] v;
        logic [31:0] otp;
        int          pick;
        pick = $urandom_range(0, 99);
        v = ($urandom_range(0, 3) == 0) ? rnd64() : sb.epoch_start + 64'($urandom);
        if ($urandom_range(0, 7) == 0) v = 64'($urandom_range(0, 200));
        if (pick < 12) begin
            send_beat(OP_KEY, 4'($urandom), rnd64(), rnd64(), $urandom);
        end else if (pick < 42) begin
            send_beat(OP_HOTP, 4'($urandom), rnd64(), v, $urandom);
        end else if (pick < 67) begin
            send_beat(OP_TOTP, 4'($urandom), rnd64(), v, $urandom);
        end else begin
            case ($urandom_range(0, 4))
                0:       otp = $urandom;
                1:       otp = $urandom_range(0, sb.modulus() - 1);
                default: otp = window_code(v);
            endcase
            send_beat(OP_VERIFY, 4'($urandom), rnd64(), v, otp);
        end
    endtask

    initial begin
        logic [7:0]  kl;
        logic [31:0] st;
        logic [63:0] ep;
        logic [7:0]  dr;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty key under reset defaults, counter extremes
        send_beat(OP_HOTP, 4'h0, '0, 64'd0, '0);
        send_beat(OP_HOTP, 4'hF, '1, '1, '1);
        // fill the whole store so no key length can reach an unwritten word
        for (int i = 0; i < 16; i++)
            send_beat(OP_KEY, 4'(i), (i == 0) ? 64'h3132333435363738 :
                      (i == 1) ? '1 : (i == 2) ? '0 : rnd64(), rnd64(), $urandom);
        drain();

        // zero digits, zero step, time before epoch, negative drift
        program_regs(8'd20, 4'd0, 32'd0, 64'd1000, 8'hFF);
        send_beat(OP_TOTP, 4'h0, '0, 64'd5, '0);
        send_beat(OP_VERIFY, 4'h0, '0, 64'd5000, window_code(64'd5000));
        drain();

        // oversize key length, too many digits, one-second step, time extremes
        program_regs(8'd255, 4'd15, 32'd1, 64'd0, 8'd2);
        send_beat(OP_TOTP, 4'h0, '0, '1, '0);
        send_beat(OP_VERIFY, 4'h0, '0, '1, window_code('1));
        send_beat(OP_VERIFY, 4'h0, '0, 64'd0, window_code(64'd0));
        send_beat(OP_VERIFY, 4'h0, '0, 64'd1, 32'hFFFF_FFFF);
        drain();

        // widest drift, key just over one block, largest step
        program_regs(8'd65, 4'd9, 32'hFFFF_FFFF, '1, 8'd127);
        send_beat(OP_VERIFY, 4'h0, '0, 64'd3, '0);
        drain();
        // indexes past the register list go nowhere
        write_reg(3'd5, rnd64());
        write_reg(3'd6, rnd64());
        write_reg(3'd7, rnd64());
        program_regs(8'd64, 4'd8, 32'd59, 64'd1, 8'h80);
        send_beat(OP_HOTP, 4'h0, '0, rnd64(), '0);
        send_beat(OP_VERIFY, 4'h0, '0, rnd64(), '0);
        drain();

        // random phases, each under fresh settings
        for (int ph = 0; ph < 7; ph++) begin
            case ($urandom_range(0, 4))
                0:       kl = 8'($urandom_range(0, 20));
                1:       kl = 8'($urandom_range(21, 64));
                2:       kl = 8'($urandom_range(65, 128));
                3:       kl = 8'($urandom_range(129, 255));
                default: kl = 8'(($urandom_range(0, 1) == 0) ? 64 : 128);
            endcase
            case ($urandom_range(0, 3))
                0:       st = 32'd0;
                1:       st = 32'($urandom_range(1, 100));
                2:       st = 32'd1;
                default: st = $urandom;
            endcase
            ep = ($urandom_range(0, 1) == 0) ? 64'($urandom) : rnd64();
            dr = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                             : 8'($urandom_range(0, 3));
            program_regs(kl, 4'($urandom), st, ep, dr);
            if (ph == 6)
                calm = 1'b1;
            for (int n = 0; n < 200; n++)
                random_beat();
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
